### rtl/ptts_pkg.sv
// Shared types and constants for the periodic task tick scheduler.
`timescale 1ns / 1ps
`default_nettype none
package ptts_pkg;

   localparam int MAX_TASKS   = 4;
   localparam int SLOT_W      = $clog2(MAX_TASKS);
   localparam int TASK_CNT_W  = 3;
   localparam int TIME_W      = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic [2:0] CSR_TASK_COUNT = 3'd0;
   localparam logic [2:0] CSR_PERIOD_0   = 3'd1;
   localparam logic [2:0] CSR_PERIOD_1   = 3'd2;
   localparam logic [2:0] CSR_PERIOD_2   = 3'd3;
   localparam logic [2:0] CSR_PERIOD_3   = 3'd4;

   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_FETCH = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_READ   = 3'b010,
      ST_MODIFY = 3'b100
   } state_type;

   typedef struct packed {
      mode_type           mode;
      logic [TIME_W-1:0]  now_ms;
      logic [1:0]         task_index;
   } req_type;

   typedef struct packed {
      logic       newly_due;
      logic       found;
      logic [1:0] ready_index;
   } rsp_type;

endpackage
`default_nettype wire

### rtl/periodic_task_tick_scheduler.sv
// Top level of the periodic task tick scheduler.
//
//   channel   ports                              transfer when
//   request   start, busy, req_data              start & !busy
//   response  rsp_strobe, rsp_data               rsp_strobe (one cycle, no stall)
//   csr       psel, penable, pwrite, paddr,      psel & penable & pwrite & pready
//             pwdata, prdata, pready
//
// Start, fetch, clear and a tick with no elapsed time or no slots in use are served
// straight from idle; the response follows in the next cycle. A tick walks the
// counter RAM over the slots in use, with a read state and a write-back state per
// slot, and holds busy until the last slot is done. Reset clears the time, the ready
// marks and the per-entry valid bits of the counter RAM, so counters read as zero.
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_tick_scheduler (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire ptts_pkg::req_type             req_data,
   output logic                               rsp_strobe,
   output ptts_pkg::rsp_type                  rsp_data,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [ptts_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [ptts_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ptts_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import ptts_pkg::*;

   logic [TASK_CNT_W-1:0] task_count_ff;
   logic [TIME_W-1:0]     period_ff [MAX_TASKS];
   logic [TIME_W-1:0]     prev_time_ff, prev_time_in;
   logic [TIME_W-1:0]     delta_ff, delta_in;
   logic [MAX_TASKS-1:0]  ready_ff, ready_in;
   logic [MAX_TASKS-1:0]  valid_ff, valid_in;
   state_type             state_ff, state_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic                  due_ff, due_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [TASK_CNT_W-1:0] slots_used;
   logic [MAX_TASKS-1:0]  in_use;
   logic                  accept;
   logic                  csr_write;
   logic [2:0]            csr_index;
   logic                  ram_we;
   logic [TIME_W-1:0]     ram_wdata;
   logic                  ram_re;
   logic [TIME_W-1:0]     ram_rdata;
   logic [TIME_W-1:0]     count_cur;
   logic [TIME_W:0]       count_sum;
   logic [TIME_W-1:0]     count_sat;
   logic                  slot_hit;
   logic                  slot_last;
   logic                  fetch_found;
   logic [SLOT_W-1:0]     fetch_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= '0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            period_ff[i] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TASK_COUNT: task_count_ff <= pwdata[TASK_CNT_W-1:0];
            CSR_PERIOD_0:   period_ff[0]  <= pwdata;
            CSR_PERIOD_1:   period_ff[1]  <= pwdata;
            CSR_PERIOD_2:   period_ff[2]  <= pwdata;
            CSR_PERIOD_3:   period_ff[3]  <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_TASK_COUNT: prdata = {{(CSR_DATA_W-TASK_CNT_W){1'b0}}, task_count_ff};
         CSR_PERIOD_0:   prdata = period_ff[0];
         CSR_PERIOD_1:   prdata = period_ff[1];
         CSR_PERIOD_2:   prdata = period_ff[2];
         CSR_PERIOD_3:   prdata = period_ff[3];
         default:        prdata = '0;
      endcase
   end

   assign slots_used = (task_count_ff > TASK_CNT_W'(MAX_TASKS)) ?
                       TASK_CNT_W'(MAX_TASKS) : task_count_ff;

   always_comb begin
      for (int i = 0; i < MAX_TASKS; i++) begin
         in_use[i] = TASK_CNT_W'(i) < slots_used;
      end
      fetch_found = 1'b0;
      fetch_index = '0;
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (in_use[i] && ready_ff[i]) begin
            fetch_found = 1'b1;
            fetch_index = SLOT_W'(i);
         end
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   ptts_ram #(
      .WIDTH(TIME_W),
      .DEPTH(MAX_TASKS)
   ) u_count_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(slot_ff),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(slot_ff),
      .rdata(ram_rdata)
   );

   assign ram_re    = (state_ff == ST_READ);
   assign count_cur = valid_ff[slot_ff] ? ram_rdata : '0;
   assign count_sum = {1'b0, count_cur} + {1'b0, delta_ff};
   assign count_sat = count_sum[TIME_W] ? '1 : count_sum[TIME_W-1:0];
   assign slot_hit  = (period_ff[slot_ff] != '0) && (count_sat >= period_ff[slot_ff]);
   assign slot_last = (TASK_CNT_W'(slot_ff) + TASK_CNT_W'(1)) == slots_used;
   assign ram_we    = (state_ff == ST_MODIFY) && (period_ff[slot_ff] != '0);
   assign ram_wdata = slot_hit ? '0 : count_sat;

   always_comb begin
      state_in      = state_ff;
      prev_time_in  = prev_time_ff;
      delta_in      = delta_ff;
      ready_in      = ready_ff;
      valid_in      = valid_ff;
      slot_in       = slot_ff;
      due_in        = due_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_data_in = '0;
               unique case (req_data.mode)
                  MODE_START: begin
                     prev_time_in  = req_data.now_ms;
                     rsp_strobe_in = 1'b1;
                  end
                  MODE_TICK: begin
                     if (req_data.now_ms == prev_time_ff) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        prev_time_in = req_data.now_ms;
                        delta_in     = req_data.now_ms - prev_time_ff;
                        if (slots_used == '0) begin
                           rsp_strobe_in = 1'b1;
                        end else begin
                           slot_in  = '0;
                           due_in   = 1'b0;
                           state_in = ST_READ;
                        end
                     end
                  end
                  MODE_FETCH: begin
                     rsp_data_in.found       = fetch_found;
                     rsp_data_in.ready_index = fetch_index;
                     rsp_strobe_in           = 1'b1;
                  end
                  MODE_CLEAR: begin
                     ready_in[req_data.task_index] = 1'b0;
                     rsp_strobe_in                 = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (ram_we) begin
               valid_in[slot_ff] = 1'b1;
            end
            if (slot_hit) begin
               ready_in[slot_ff] = 1'b1;
            end
            if (slot_last) begin
               rsp_data_in           = '0;
               rsp_data_in.newly_due = due_ff | slot_hit;
               rsp_strobe_in         = 1'b1;
               state_in              = ST_IDLE;
            end else begin
               due_in   = due_ff | slot_hit;
               slot_in  = slot_ff + SLOT_W'(1);
               state_in = ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_time_ff  <= '0;
         ready_ff      <= '0;
         valid_ff      <= '0;
         slot_ff       <= '0;
         due_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_time_ff  <= prev_time_in;
         ready_ff      <= ready_in;
         valid_ff      <= valid_in;
         slot_ff       <= slot_in;
         due_ff        <= due_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff    <= delta_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
`default_nettype wire

### rtl/ptts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ptts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

### verif/periodic_task_tick_scheduler_tb.sv
// Self-checking testbench for the periodic task tick scheduler: directed table, then random phases.
`timescale 1ns / 1ps
module periodic_task_tick_scheduler_tb;
   import ptts_pkg::*;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   periodic_task_tick_scheduler dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   typedef struct {
      bit          is_csr;
      logic [2:0]  reg_idx;
      logic [31:0] value;
      req_type     req;
      bit          typed;
      rsp_type     rsp;
   } plan_row_type;

   // scheduler state as seen from outside
   logic [2:0]  slots_cfg;
   logic [31:0] period_cfg [MAX_TASKS];
   logic [31:0] last_time;
   logic [31:0] tick_total [MAX_TASKS];
   logic        ready_flag [MAX_TASKS];

   rsp_type      pending_reports [$];
   plan_row_type plan [$];
   int           mismatch_count;
   int           shown_count;
   logic [31:0]  cur_time;
   bit           idling;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("periodic_task_tick_scheduler_tb: done, errors");
      $finish;
   end

   function automatic void schedule_step(input req_type r, output rsp_type o);
      logic [31:0] delta;
      logic [32:0] sum;
      int          n;
      o = '0;
      n = (slots_cfg > MAX_TASKS) ? MAX_TASKS : int'(slots_cfg);
      case (r.mode)
         MODE_START: begin
            last_time = r.now_ms;
         end
         MODE_TICK: begin
            if (r.now_ms != last_time) begin
               delta = r.now_ms - last_time;
               last_time = r.now_ms;
               for (int i = 0; i < n; i++) begin
                  if (period_cfg[i] != 0) begin
                     sum = {1'b0, tick_total[i]} + {1'b0, delta};
                     tick_total[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                     if (tick_total[i] >= period_cfg[i]) begin
                        tick_total[i] = '0;
                        ready_flag[i] = 1'b1;
                        o.newly_due = 1'b1;
                     end
                  end
               end
            end
         end
         MODE_FETCH: begin
            for (int i = 0; i < n; i++) begin
               if (ready_flag[i] && !o.found) begin
                  o.found = 1'b1;
                  o.ready_index = 2'(i);
               end
            end
         end
         default: begin
            ready_flag[r.task_index] = 1'b0;
         end
      endcase
   endfunction

   function automatic req_type make_req(input mode_type m, input logic [31:0] t,
                                        input logic [1:0] idx);
      req_type r;
      r.mode = m;
      r.now_ms = t;
      r.task_index = idx;
      return r;
   endfunction

   function automatic void plan_item(input mode_type m, input logic [31:0] t,
                                     input logic [1:0] idx);
      plan_row_type p;
      p = '{default: '0};
      p.req = make_req(m, t, idx);
      plan.push_back(p);
   endfunction

   function automatic void plan_check(input mode_type m, input logic [31:0] t,
                                      input logic [1:0] idx, input logic due,
                                      input logic fnd, input logic [1:0] which);
      plan_row_type p;
      p = '{default: '0};
      p.req = make_req(m, t, idx);
      p.typed = 1'b1;
      p.rsp = '{newly_due: due, found: fnd, ready_index: which};
      plan.push_back(p);
   endfunction

   function automatic void plan_csr(input logic [2:0] idx, input logic [31:0] val);
      plan_row_type p;
      p = '{default: '0};
      p.is_csr = 1'b1;
      p.reg_idx = idx;
      p.value = val;
      plan.push_back(p);
   endfunction

   function automatic logic [31:0] pick_period();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 32'd0;
      if (r < 20) return 32'd1;
      if (r < 70) return 32'($urandom_range(2, 40));
      if (r < 80) return 32'hFFFF_FFFF;
      if (r < 90) return $urandom();
      return 32'($urandom_range(41, 5000));
   endfunction

   function automatic req_type random_req();
      req_type r;
      int      pick;
      int      step;
      r.now_ms = $urandom();
      r.task_index = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r.mode = MODE_TICK;
         step = $urandom_range(0, 99);
         if (step < 10) r.now_ms = cur_time;
         else if (step < 70) r.now_ms = cur_time + 32'($urandom_range(1, 8));
         else if (step < 85) r.now_ms = cur_time + 32'($urandom_range(9, 1000));
         cur_time = r.now_ms;
      end else if (pick < 55) begin
         r.mode = MODE_START;
         if ($urandom_range(0, 1)) r.now_ms = cur_time;
         cur_time = r.now_ms;
      end else if (pick < 80) begin
         r.mode = MODE_FETCH;
      end else begin
         r.mode = MODE_CLEAR;
      end
      return r;
   endfunction

   task automatic send_req(input req_type r, input bit typed, input rsp_type fixed);
      rsp_type guess;
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      schedule_step(r, guess);
      pending_reports.push_back(typed ? fixed : guess);
   endtask

   task automatic hold_off(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic maybe_gap();
      if (idling && $urandom_range(0, 99) < 21) hold_off($urandom_range(1, 4));
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         CSR_TASK_COUNT: slots_cfg = val[2:0];
         CSR_PERIOD_0:   period_cfg[0] = val;
         CSR_PERIOD_1:   period_cfg[1] = val;
         CSR_PERIOD_2:   period_cfg[2] = val;
         CSR_PERIOD_3:   period_cfg[3] = val;
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (shown_count < 10) begin
               shown_count++;
               $display("unexpected transfer: due=%0d found=%0d idx=%0d",
                        rsp_data.newly_due, rsp_data.found, rsp_data.ready_index);
            end
         end else begin
            want = pending_reports.pop_front();
            if (rsp_data.newly_due !== want.newly_due || rsp_data.found !== want.found ||
                rsp_data.ready_index !== want.ready_index) begin
               mismatch_count++;
               if (shown_count < 10) begin
                  shown_count++;
                  $display({"mismatch: exp due=%0d found=%0d idx=%0d,",
                            " got due=%0d found=%0d idx=%0d"},
                           want.newly_due, want.found, want.ready_index,
                           rsp_data.newly_due, rsp_data.found, rsp_data.ready_index);
               end
            end
         end
      end
   end

   initial begin
      int phase_slots [6];
      int waited;
      phase_slots = '{4, 7, 2, 4, 0, 3};
      mismatch_count = 0;
      shown_count = 0;
      cur_time = '0;
      idling = 1'b1;
      slots_cfg = '0;
      last_time = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         period_cfg[i] = '0;
         tick_total[i] = '0;
         ready_flag[i] = 1'b0;
      end
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nothing in use after reset
      plan_check(MODE_FETCH, 32'h0, 2'd0, 1'b0, 1'b0, 2'd0);
      plan_check(MODE_TICK, 32'd100, 2'd1, 1'b0, 1'b0, 2'd0);
      plan_check(MODE_CLEAR, 32'hFFFF_FFFF, 2'd3, 1'b0, 1'b0, 2'd0);
      // count above the table size acts as full table
      plan_csr(CSR_TASK_COUNT, 32'd7);
      plan_csr(CSR_PERIOD_0, 32'd1);
      plan_csr(CSR_PERIOD_1, 32'hFFFF_FFFF);
      plan_csr(CSR_PERIOD_2, 32'd3);
      plan_csr(CSR_PERIOD_3, 32'd0);
      plan_check(MODE_START, 32'hFFFF_FFF0, 2'd2, 1'b0, 1'b0, 2'd0);
      plan_check(MODE_TICK, 32'hFFFF_FFF0, 2'd0, 1'b0, 1'b0, 2'd0);
      // time wrap, delta of 17
      plan_check(MODE_TICK, 32'h0000_0001, 2'd3, 1'b1, 1'b0, 2'd0);
      plan_check(MODE_FETCH, 32'h5A5A_5A5A, 2'd0, 1'b0, 1'b1, 2'd0);
      plan_check(MODE_FETCH, 32'hA5A5_A5A5, 2'd1, 1'b0, 1'b1, 2'd0);
      plan_check(MODE_CLEAR, 32'h0, 2'd0, 1'b0, 1'b0, 2'd0);
      plan_check(MODE_FETCH, 32'h0, 2'd0, 1'b0, 1'b1, 2'd2);
      plan_check(MODE_CLEAR, 32'h0, 2'd2, 1'b0, 1'b0, 2'd0);
      plan_check(MODE_FETCH, 32'h0, 2'd0, 1'b0, 1'b0, 2'd0);
      // counter saturation
      plan_item(MODE_START, 32'h0, 2'd1);
      plan_item(MODE_TICK, 32'hFFFF_FFFF, 2'd2);
      plan_item(MODE_FETCH, 32'h0, 2'd3);
      // slots beyond the count are frozen and hidden
      plan_csr(CSR_TASK_COUNT, 32'd1);
      plan_item(MODE_CLEAR, 32'h0, 2'd0);
      plan_item(MODE_FETCH, 32'h0, 2'd0);
      plan_item(MODE_TICK, 32'h0000_0002, 2'd0);
      plan_item(MODE_CLEAR, 32'h0, 2'd2);
      plan_csr(CSR_TASK_COUNT, 32'd4);
      plan_item(MODE_FETCH, 32'h0, 2'd0);
      plan_item(MODE_CLEAR, 32'h0, 2'd0);
      plan_item(MODE_FETCH, 32'h0, 2'd0);
      plan_csr(CSR_PERIOD_3, 32'd2);
      plan_item(MODE_TICK, 32'h0000_0003, 2'd1);
      plan_item(MODE_TICK, 32'h8000_0004, 2'd3);
      plan_item(MODE_FETCH, 32'h0, 2'd2);

      foreach (plan[k]) begin
         if (plan[k].is_csr) begin
            drain();
            csr_write(plan[k].reg_idx, plan[k].value);
         end else begin
            send_req(plan[k].req, plan[k].typed, plan[k].rsp);
            maybe_gap();
         end
      end
      cur_time = last_time;

      for (int p = 0; p < 6; p++) begin
         drain();
         csr_write(CSR_TASK_COUNT, 32'(phase_slots[p]));
         csr_write(CSR_PERIOD_0, pick_period());
         csr_write(CSR_PERIOD_1, pick_period());
         csr_write(CSR_PERIOD_2, pick_period());
         csr_write(CSR_PERIOD_3, pick_period());
         idling = (p != 2);
         repeat (100) begin
            send_req(random_req(), 1'b0, '0);
            maybe_gap();
         end
      end

      @(negedge clock);
      start <= 1'b0;
      waited = 0;
      while (pending_reports.size() != 0 && waited < 200) begin
         @(posedge clock);
         waited++;
      end
      repeat (12) @(posedge clock);
      mismatch_count += pending_reports.size();
      if (mismatch_count == 0) begin
         $display("periodic_task_tick_scheduler_tb: done, clean");
      end else begin
         $display("periodic_task_tick_scheduler_tb: done, errors");
      end
      $finish;
   end

endmodule
